/* sv/sor_poisson_relaxation_macros.svh */
// Assertion macros used by the checker file.
`ifndef SOR_POISSON_RELAXATION_MACROS_SVH
`define SOR_POISSON_RELAXATION_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SORPR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sor_poisson_relaxation assertion failed");

// Clocked assertion that also holds across reset.
`define SORPR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sor_poisson_relaxation assertion failed");

`endif

/* sv/sorpr_pkg.sv */
package sorpr_pkg;

  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 128;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_SOLVE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [2:0] CFG_GRID_COLS    = 3'd0;
  localparam logic [2:0] CFG_GRID_ROWS    = 3'd1;
  localparam logic [2:0] CFG_RELAX_FACTOR = 3'd2;
  localparam logic [2:0] CFG_STEP_SQ      = 3'd3;
  localparam logic [2:0] CFG_REL_TOL      = 3'd4;
  localparam logic [2:0] CFG_SWEEP_LIMIT  = 3'd5;

  typedef struct packed {
    logic               start;
    logic signed [63:0] prev;
    logic signed [63:0] cur;
  } conv_req_t;

  typedef struct packed {
    logic done;
    logic converged;
  } conv_rsp_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
      return 64'sh7FFF_FFFF_FFFF_FFFF;
    end else if (s < -65'sh0_8000_0000_0000_0000) begin
      return 64'sh8000_0000_0000_0000;
    end
    return s[63:0];
  endfunction

endpackage

/* sv/sorpr_if.sv */
interface sorpr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           req_type;
  logic [sorpr_pkg::ROW_W-1:0]          row;
  logic [sorpr_pkg::COL_W-1:0]          col;
  logic signed [31:0]                   cell_potential;
  logic signed [31:0]                   cell_density;
  modport source (output valid, req_type, row, col, cell_potential, cell_density,
                  input ready);
  modport sink (input valid, req_type, row, col, cell_potential, cell_density,
                output ready);
endinterface

interface sorpr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_potential;
  logic [19:0]        sweep_count;
  logic               limit_hit;
  modport source (output valid, read_potential, sweep_count, limit_hit, input ready);
  modport sink (input valid, read_potential, sweep_count, limit_hit, output ready);
endinterface

interface sorpr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [31:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

/* sv/sor_poisson_relaxation.sv */
// A cell write gives its item in the next cycle; a read passes the ST_READ state before its item is registered.
// Writes are taken one per cycle while the output is not stalled; a read closes the input until its item is loaded.
// A solve works through every interior cell and then every energy cell in each sweep,
// one phase at a time, since the potential memory has a single read port, and ends
// each sweep with the convergence test.
// After reset a clearing pass zeroes every address of both memories; no item
// is accepted meanwhile, configuration writes are.
module sor_poisson_relaxation (
  input  logic         clk,
  input  logic         rst_n,
  sorpr_in_if.sink     in_ch,
  sorpr_out_if.source  out_ch,
  sorpr_cfg_if.sink    cfg_ch
);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_READ   = 4'd2;
  localparam logic [3:0] ST_SWEEP  = 4'd3;
  localparam logic [3:0] ST_ENERGY = 4'd4;
  localparam logic [3:0] ST_CONV   = 4'd5;
  localparam logic [3:0] ST_WAIT   = 4'd6;

  localparam int RW = sorpr_pkg::ROW_W;
  localparam int CW = sorpr_pkg::COL_W;
  localparam int AW = sorpr_pkg::ADDR_W;

  logic [3:0]  state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic [RW-1:0] i_r;
  logic [CW-1:0] j_r;
  logic [3:0]  ph_r;

  logic [7:0]  grid_cols_r, grid_rows_r;
  logic [14:0] relax_factor_r;
  logic [31:0] step_sq_r, rel_tol_r;
  logic [19:0] sweep_limit_r;

  logic [19:0] sweeps_r;
  logic        stopped_r;
  logic signed [63:0] e_cur_r, e_acc_r;

  logic        out_valid_r, out_valid_nxt;
  logic signed [31:0] out_pot_r;
  logic [19:0] out_cnt_r;
  logic        out_lim_r;

  logic signed [31:0] pot_mem [sorpr_pkg::DEPTH];
  logic signed [31:0] den_mem [sorpr_pkg::DEPTH];
  logic signed [31:0] pot_q, den_q;
  logic [AW-1:0] pot_raddr, pot_waddr;
  logic          pot_we, den_we;
  logic signed [31:0] pot_wdata, den_wdata;

  logic signed [31:0] a_r, r_r;
  logic signed [63:0] prod_r;
  logic signed [35:0] acc_r;
  logic signed [51:0] mul_r;
  logic [31:0] dvm_r, dhm_r;
  logic [63:0] sv_r, sh_r, qlo_r;
  logic signed [63:0] p_r;
  logic [62:0] m_r, qhi_r;
  logic signed [63:0] kin_r, potq_r;

  logic [7:0]  rows_use, cols_use;
  logic [RW-1:0] rows_m2;
  logic [CW-1:0] cols_m2;
  logic [19:0] limit_use;
  logic        in_acc, row_end, last_row, finish, out_load;
  logic [AW-1:0] addr_c, addr_in;

  logic signed [64:0] prod_full;
  logic signed [63:0] src_rnd;
  logic signed [51:0] mul_rnd;
  logic signed [36:0] v_sum;
  logic signed [31:0] v_sat;
  logic signed [32:0] dd;
  logic [32:0] dd_mag;
  logic [63:0] p_mag;
  logic [64:0] kin_sum;
  logic [63:0] qlo_rnd;

  sorpr_pkg::conv_req_t conv_req;
  sorpr_pkg::conv_rsp_t conv_rsp;

  always_comb begin
    if (grid_rows_r < 8'd3) rows_use = 8'd3;
    else if (grid_rows_r > 8'(sorpr_pkg::MAX_ROWS)) rows_use = 8'(sorpr_pkg::MAX_ROWS);
    else rows_use = grid_rows_r;
    if (grid_cols_r < 8'd3) cols_use = 8'd3;
    else if (grid_cols_r > 8'(sorpr_pkg::MAX_COLS)) cols_use = 8'(sorpr_pkg::MAX_COLS);
    else cols_use = grid_cols_r;
  end

  assign rows_m2   = RW'(rows_use - 8'd2);
  assign cols_m2   = CW'(cols_use - 8'd2);
  assign limit_use = (sweep_limit_r == 20'd0) ? 20'd1 : sweep_limit_r;
  assign row_end   = (j_r == cols_m2);
  assign last_row  = (i_r == rows_m2);
  assign addr_c    = {i_r, j_r};
  assign addr_in   = {in_ch.row, in_ch.col};

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign finish = (state_r == ST_WAIT) && conv_rsp.done &&
                  (conv_rsp.converged || sweeps_r >= limit_use);
  assign out_load = (in_acc && in_ch.req_type != sorpr_pkg::REQ_SOLVE &&
                     in_ch.req_type != sorpr_pkg::REQ_READ) ||
                    (state_r == ST_READ) || finish;
  assign out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (&clr_cnt_r) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc && in_ch.req_type == sorpr_pkg::REQ_SOLVE) state_nxt = ST_SWEEP;
        else if (in_acc && in_ch.req_type == sorpr_pkg::REQ_READ) state_nxt = ST_READ;
      end
      ST_READ:   state_nxt = ST_IDLE;
      ST_SWEEP:  if (ph_r == 4'd8 && row_end && last_row) state_nxt = ST_ENERGY;
      ST_ENERGY: if (ph_r == 4'd7 && row_end && last_row) state_nxt = ST_CONV;
      ST_CONV:   state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (finish) state_nxt = ST_IDLE;
        else if (conv_rsp.done) state_nxt = ST_SWEEP;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Memory port selection.
  always_comb begin
    pot_raddr = addr_c;
    if (state_r == ST_IDLE) begin
      pot_raddr = addr_in;
    end else if (state_r == ST_SWEEP) begin
      unique case (ph_r)
        4'd1:    pot_raddr = {RW'(i_r - 1'b1), j_r};
        4'd2:    pot_raddr = {RW'(i_r + 1'b1), j_r};
        4'd3:    pot_raddr = {i_r, CW'(j_r - 1'b1)};
        4'd4:    pot_raddr = {i_r, CW'(j_r + 1'b1)};
        default: pot_raddr = addr_c;
      endcase
    end else if (state_r == ST_ENERGY) begin
      unique case (ph_r)
        4'd1:    pot_raddr = {RW'(i_r + 1'b1), j_r};
        4'd2:    pot_raddr = {i_r, CW'(j_r + 1'b1)};
        default: pot_raddr = addr_c;
      endcase
    end
  end

  always_comb begin
    pot_we    = 1'b0;
    den_we    = 1'b0;
    pot_waddr = addr_in;
    pot_wdata = in_ch.cell_potential;
    den_wdata = in_ch.cell_density;
    if (state_r == ST_CLEAR) begin
      pot_we    = 1'b1;
      den_we    = 1'b1;
      pot_waddr = clr_cnt_r;
      pot_wdata = '0;
      den_wdata = '0;
    end else if (in_acc && in_ch.req_type == sorpr_pkg::REQ_WRITE) begin
      pot_we = 1'b1;
      den_we = 1'b1;
    end else if (state_r == ST_SWEEP && ph_r == 4'd8) begin
      pot_we    = 1'b1;
      pot_waddr = addr_c;
      pot_wdata = v_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (pot_we) pot_mem[pot_waddr] <= pot_wdata;
    pot_q <= pot_mem[pot_raddr];
  end

  always_ff @(posedge clk) begin
    if (den_we) den_mem[pot_waddr] <= den_wdata;
    den_q <= den_mem[addr_c];
  end

  // Arithmetic of the sweep update and of the energy terms.
  assign prod_full = $signed({1'b0, step_sq_r}) * r_r;
  assign src_rnd   = prod_r + 64'sh8000_0000;
  assign mul_rnd   = mul_r + 52'sd32768;
  assign v_sum     = 37'(a_r) + 37'($signed(mul_rnd[51:16]));
  always_comb begin
    if (v_sum > 37'sh0_7FFF_FFFF) v_sat = 32'sh7FFF_FFFF;
    else if (v_sum < -37'sh0_8000_0000) v_sat = 32'sh8000_0000;
    else v_sat = v_sum[31:0];
  end
  assign dd      = 33'(pot_q) - 33'(a_r);
  assign dd_mag  = dd[32] ? 33'(-dd) : 33'(dd);
  assign p_mag   = p_r[63] ? 64'(-p_r) : 64'(p_r);
  assign kin_sum = 65'(sv_r >> 1) + 65'(sh_r >> 1) + 65'(sv_r[0] & sh_r[0]);
  assign qlo_rnd = qlo_r + 64'h8000_0000;

  always_ff @(posedge clk) begin
    unique case (ph_r)
      4'd1: begin
        a_r <= pot_q;
        r_r <= den_q;
      end
      4'd2: begin
        prod_r <= prod_full[63:0];
        acc_r  <= 36'(pot_q);
        dvm_r  <= dd_mag[31:0];
        p_r    <= a_r * r_r;
      end
      4'd3: begin
        acc_r <= acc_r + 36'(pot_q);
        dhm_r <= dd_mag[31:0];
        sv_r  <= dvm_r * dvm_r;
        m_r   <= p_mag[62:0];
      end
      4'd4: begin
        acc_r <= acc_r + 36'(pot_q);
        sh_r  <= dhm_r * dhm_r;
        qlo_r <= m_r[31:0] * step_sq_r;
      end
      4'd5: begin
        acc_r <= acc_r + 36'(pot_q);
        qhi_r <= m_r[62:32] * step_sq_r;
        kin_r <= kin_sum[64:63] != 2'b00 ? 64'sh7FFF_FFFF_FFFF_FFFF : kin_sum[63:0];
      end
      4'd6: begin
        acc_r  <= acc_r + 36'($signed(src_rnd[63:32])) - (36'(a_r) <<< 2);
        potq_r <= 64'(qhi_r) + 64'(qlo_rnd[63:32]);
      end
      4'd7: begin
        mul_r <= $signed({1'b0, relax_factor_r}) * acc_r;
      end
      default: begin
      end
    endcase
  end

  assign conv_req.start = (state_r == ST_CONV);
  assign conv_req.prev  = e_cur_r;
  assign conv_req.cur   = e_acc_r;

  sorpr_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (conv_req),
    .tol   (rel_tol_r),
    .rsp   (conv_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_cnt_r      <= '0;
      out_valid_r    <= 1'b0;
      grid_cols_r    <= 8'd100;
      grid_rows_r    <= 8'd80;
      relax_factor_r <= 15'd31130;
      step_sq_r      <= 32'd429497;
      rel_tol_r      <= 32'd429;
      sweep_limit_r  <= 20'd100000;
      sweeps_r       <= '0;
      stopped_r      <= 1'b0;
      e_cur_r        <= '0;
      e_acc_r        <= '0;
      i_r            <= '0;
      j_r            <= '0;
      ph_r           <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;

      if (cfg_ch.valid) begin
        unique case (cfg_ch.reg_index)
          sorpr_pkg::CFG_GRID_COLS:    grid_cols_r    <= cfg_ch.wdata[7:0];
          sorpr_pkg::CFG_GRID_ROWS:    grid_rows_r    <= cfg_ch.wdata[7:0];
          sorpr_pkg::CFG_RELAX_FACTOR: relax_factor_r <= cfg_ch.wdata[14:0];
          sorpr_pkg::CFG_STEP_SQ:      step_sq_r      <= cfg_ch.wdata;
          sorpr_pkg::CFG_REL_TOL:      rel_tol_r      <= cfg_ch.wdata;
          sorpr_pkg::CFG_SWEEP_LIMIT:  sweep_limit_r  <= cfg_ch.wdata[19:0];
          default: begin
          end
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && in_ch.req_type == sorpr_pkg::REQ_SOLVE) begin
            sweeps_r  <= '0;
            stopped_r <= 1'b0;
            e_cur_r   <= '0;
            i_r       <= RW'(1);
            j_r       <= CW'(1);
            ph_r      <= '0;
          end
        end
        ST_SWEEP: begin
          if (ph_r == 4'd8) begin
            ph_r <= '0;
            if (row_end) begin
              j_r <= CW'(1);
              i_r <= i_r + 1'b1;
              if (last_row) begin
                i_r      <= '0;
                j_r      <= '0;
                e_acc_r  <= '0;
                sweeps_r <= sweeps_r + 1'b1;
              end
            end else begin
              j_r <= j_r + 1'b1;
            end
          end else begin
            ph_r <= ph_r + 1'b1;
          end
        end
        ST_ENERGY: begin
          if (ph_r == 4'd6) e_acc_r <= sorpr_pkg::sat_add(e_acc_r, kin_r);
          if (ph_r == 4'd7) begin
            e_acc_r <= sorpr_pkg::sat_add(e_acc_r, p_r[63] ? potq_r : -potq_r);
            ph_r    <= '0;
            if (row_end) begin
              j_r <= '0;
              i_r <= i_r + 1'b1;
            end else begin
              j_r <= j_r + 1'b1;
            end
          end else begin
            ph_r <= ph_r + 1'b1;
          end
        end
        ST_CONV: begin
          e_cur_r <= e_acc_r;
        end
        ST_WAIT: begin
          if (conv_rsp.done && !conv_rsp.converged && sweeps_r >= limit_use) begin
            stopped_r <= 1'b1;
          end
          i_r  <= RW'(1);
          j_r  <= CW'(1);
          ph_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pot_r <= (state_r == ST_READ) ? pot_q : 32'sd0;
      out_cnt_r <= sweeps_r;
      out_lim_r <= finish ? !conv_rsp.converged : stopped_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.read_potential = out_pot_r;
  assign out_ch.sweep_count    = out_cnt_r;
  assign out_ch.limit_hit      = out_lim_r;

endmodule

/* sv/sorpr_conv.sv */
// Relative change test |cur - prev| * 2^32 <= tol * |prev|, with tol * |prev| formed in two halves.
module sorpr_conv (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sorpr_pkg::conv_req_t req,
  input  logic [31:0]          tol,
  output sorpr_pkg::conv_rsp_t rsp
);

  logic [1:0]         step_r;
  logic [1:0]         step_nxt;
  logic               done_r;
  logic               conv_r;
  logic [63:0]        diff_r;
  logic [63:0]        pmag_r;
  logic [63:0]        t1_r;
  logic [63:0]        t2_r;
  logic signed [64:0] delta;
  logic [64:0]        delta_mag;
  logic [95:0]        rhs;

  assign delta     = 65'(req.cur) - 65'(req.prev);
  assign delta_mag = delta[64] ? 65'(-delta) : 65'(delta);
  assign rhs       = (96'(t2_r) << 32) + 96'(t1_r);

  always_comb begin
    step_nxt = step_r;
    unique case (step_r)
      2'd0:    if (req.start) step_nxt = 2'd1;
      2'd1:    step_nxt = 2'd2;
      2'd2:    step_nxt = 2'd3;
      default: step_nxt = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 2'd0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= (step_r == 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (step_r == 2'd0 && req.start) begin
      diff_r <= delta_mag[63:0];
      pmag_r <= req.prev[63] ? 64'(-req.prev) : 64'(req.prev);
    end
    if (step_r == 2'd1) begin
      t1_r <= pmag_r[31:0] * tol;
    end
    if (step_r == 2'd2) begin
      t2_r <= pmag_r[63:32] * tol;
    end
    if (step_r == 2'd3) begin
      conv_r <= ({diff_r, 32'd0} <= rhs);
    end
  end

  assign rsp.done      = done_r;
  assign rsp.converged = conv_r;

endmodule

/* sv/sorpr_checker.sv */
`include "sor_poisson_relaxation_macros.svh"

module sorpr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_req_type,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_read_potential,
  input logic [19:0] out_sweep_count,
  input logic        out_limit_hit
);

  // A result that is not taken stays offered.
  `SORPR_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)

  // A stalled result keeps its payload.
  `SORPR_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_read_potential) && $stable(out_sweep_count) && $stable(out_limit_hit))

  // A cell write is answered in the next cycle with a zero potential.
  `SORPR_ASSERT(a_write_item, clk, rst_n, in_valid && in_ready && in_req_type == sorpr_pkg::REQ_WRITE |=> out_valid && out_read_potential == 32'd0)

  // Asserting reset closes the input, as the clearing pass begins.
  `SORPR_ASSERT_ALWAYS(a_reset_closed, clk, !rst_n |=> !in_ready)

endmodule

bind sor_poisson_relaxation sorpr_checker u_sorpr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .in_req_type        (in_ch.req_type),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_read_potential (out_ch.read_potential),
  .out_sweep_count    (out_ch.sweep_count),
  .out_limit_hit      (out_ch.limit_hit)
);

/* tb/sor_poisson_relaxation_tb.sv */
module sor_poisson_relaxation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] potential;
    logic [19:0]        sweeps;
    logic               at_limit;
  } cell_reply_t;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int MAX_COLS = sorpr_pkg::MAX_COLS;
  localparam logic signed [127:0] I64_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [127:0] I64_MIN = -128'sh8000_0000_0000_0000;
  localparam logic signed [127:0] I32_MAX = 128'sh7FFF_FFFF;
  localparam logic signed [127:0] I32_MIN = -128'sh8000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sorpr_in_if  in_ch();
  sorpr_out_if out_ch();
  sorpr_cfg_if cfg_ch();

  sor_poisson_relaxation i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mirror of the block's grids, registers and solve status.
  int          potential_grid[sorpr_pkg::DEPTH];
  int          density_grid[sorpr_pkg::DEPTH];
  logic [7:0]  cols_reg    = 8'd100;
  logic [7:0]  rows_reg    = 8'd80;
  logic [14:0] relax_reg   = 15'd31130;
  logic [31:0] step_sq_reg = 32'd429497;
  logic [31:0] tol_reg     = 32'd429;
  logic [19:0] limit_reg   = 20'd100000;
  int          last_sweeps;
  logic        last_at_limit;

  cell_reply_t replies_due[$];
  int failures;
  int send_idle_pct;
  int recv_stall_pct;
  int rx_cycle;
  int hold_end;
  int solves_run;
  int limit_stops;
  int reads_run;

  function automatic logic signed [127:0] sat64(input logic signed [127:0] acc,
                                                input logic signed [127:0] v);
    logic signed [127:0] s;
    s = acc + v;
    if (s > I64_MAX) return I64_MAX;
    if (s < I64_MIN) return I64_MIN;
    return s;
  endfunction

  function automatic int clamp_dim(input logic [7:0] v);
    if (v < 3) return 3;
    return (v > 128) ? 128 : int'(v);
  endfunction

  function automatic void relax_sweep(input int rows, input int cols);
    logic signed [127:0] a, r, h2, wf, src, d4, v, nsum;
    int c;
    h2 = {96'd0, step_sq_reg};
    wf = {113'd0, relax_reg};
    for (int i = 1; i + 1 < rows; i++) begin
      for (int j = 1; j + 1 < cols; j++) begin
        c = i * MAX_COLS + j;
        a = potential_grid[c];
        r = density_grid[c];
        src = (h2 * r + 128'sh8000_0000) >>> 32;
        nsum = potential_grid[c - MAX_COLS];
        nsum = nsum + potential_grid[c + MAX_COLS];
        nsum = nsum + potential_grid[c - 1];
        nsum = nsum + potential_grid[c + 1];
        d4 = nsum + src - 4 * a;
        v = a + ((wf * d4 + 128'sh8000) >>> 16);
        if (v > I32_MAX) v = I32_MAX;
        if (v < I32_MIN) v = I32_MIN;
        potential_grid[c] = int'(v[31:0]);
      end
    end
  endfunction

  function automatic logic signed [127:0] grid_energy(input int rows, input int cols);
    logic signed [127:0] e, a, dv, dh, kin, p, m, q, h2, nb;
    int c;
    e = 0;
    h2 = {96'd0, step_sq_reg};
    for (int i = 0; i + 1 < rows; i++) begin
      for (int j = 0; j + 1 < cols; j++) begin
        c = i * MAX_COLS + j;
        a = potential_grid[c];
        nb = potential_grid[c + MAX_COLS];
        dv = nb - a;
        nb = potential_grid[c + 1];
        dh = nb - a;
        kin = (dv * dv + dh * dh) >>> 1;
        if (kin > I64_MAX) kin = I64_MAX;
        nb = density_grid[c];
        p = nb * a;
        m = (p < 0) ? -p : p;
        q = (m * h2 + 128'sh8000_0000) >>> 32;
        e = sat64(e, kin);
        e = sat64(e, (p < 0) ? q : -q);
      end
    end
    return e;
  endfunction

  function automatic bit has_settled(input logic signed [127:0] prev,
                                     input logic signed [127:0] cur);
    logic signed [127:0] diff, mag;
    diff = (cur >= prev) ? cur - prev : prev - cur;
    mag = (prev < 0) ? -prev : prev;
    return (diff <<< 32) <= mag * $signed({96'd0, tol_reg});
  endfunction

  function automatic void run_solve();
    logic signed [127:0] prev, cur;
    int rows, cols, lim;
    rows = clamp_dim(rows_reg);
    cols = clamp_dim(cols_reg);
    lim = (limit_reg == 0) ? 1 : int'(limit_reg);
    cur = 0;
    last_sweeps = 0;
    last_at_limit = 1'b0;
    forever begin
      relax_sweep(rows, cols);
      last_sweeps++;
      prev = cur;
      cur = grid_energy(rows, cols);
      if (has_settled(prev, cur)) break;
      if (last_sweeps >= lim) begin
        last_at_limit = 1'b1;
        break;
      end
    end
  endfunction

  function automatic cell_reply_t predict_reply(input logic [1:0] req, input int row,
                                                input int col, input logic [31:0] pot,
                                                input logic [31:0] den);
    cell_reply_t rep;
    int c;
    c = row * MAX_COLS + col;
    rep.potential = '0;
    case (req)
      sorpr_pkg::REQ_WRITE: begin
        potential_grid[c] = int'(pot);
        density_grid[c] = int'(den);
      end
      sorpr_pkg::REQ_SOLVE: begin
        run_solve();
        solves_run++;
        if (last_at_limit) limit_stops++;
      end
      sorpr_pkg::REQ_READ: begin
        rep.potential = potential_grid[c];
        reads_run++;
      end
      default: ;
    endcase
    rep.sweeps = last_sweeps[19:0];
    rep.at_limit = last_at_limit;
    return rep;
  endfunction

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle < hold_end) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cell_reply_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (replies_due.size() == 0) begin
        $error("unexpected item: read_potential %0d", out_ch.read_potential);
        failures++;
      end else begin
        want = replies_due.pop_front();
        if (out_ch.read_potential !== want.potential) begin
          $error("read_potential: expected %0d, got %0d", want.potential,
                 out_ch.read_potential);
          failures++;
        end
        if (out_ch.sweep_count !== want.sweeps) begin
          $error("sweep_count: expected %0d, got %0d", want.sweeps, out_ch.sweep_count);
          failures++;
        end
        if (out_ch.limit_hit !== want.at_limit) begin
          $error("limit_hit: expected %0b, got %0b", want.at_limit, out_ch.limit_hit);
          failures++;
        end
      end
    end
  end

  task automatic send_item(input logic [1:0] req, input int row, input int col,
                           input logic [31:0] pot, input logic [31:0] den);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= req;
    in_ch.row <= row[sorpr_pkg::ROW_W-1:0];
    in_ch.col <= col[sorpr_pkg::COL_W-1:0];
    in_ch.cell_potential <= pot;
    in_ch.cell_density <= den;
    do @(posedge clk); while (!in_ch.ready);
    replies_due.push_back(predict_reply(req, row, col, pot, den));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (replies_due.size() > 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      sorpr_pkg::CFG_GRID_COLS:    cols_reg = value[7:0];
      sorpr_pkg::CFG_GRID_ROWS:    rows_reg = value[7:0];
      sorpr_pkg::CFG_RELAX_FACTOR: relax_reg = value[14:0];
      sorpr_pkg::CFG_STEP_SQ:      step_sq_reg = value;
      sorpr_pkg::CFG_REL_TOL:      tol_reg = value;
      sorpr_pkg::CFG_SWEEP_LIMIT:  limit_reg = value[19:0];
      default: ;
    endcase
  endtask

  task automatic set_solver(input int cols, input int rows, input int relax,
                            input logic [31:0] step, input logic [31:0] tol,
                            input int lim);
    write_reg(sorpr_pkg::CFG_GRID_COLS, cols);
    write_reg(sorpr_pkg::CFG_GRID_ROWS, rows);
    write_reg(sorpr_pkg::CFG_RELAX_FACTOR, relax);
    write_reg(sorpr_pkg::CFG_STEP_SQ, step);
    write_reg(sorpr_pkg::CFG_REL_TOL, tol);
    write_reg(sorpr_pkg::CFG_SWEEP_LIMIT, lim);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [31:0] cell_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  task automatic test_cell_access();
    send_item(sorpr_pkg::REQ_WRITE, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(sorpr_pkg::REQ_WRITE, 127, 127, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(sorpr_pkg::REQ_WRITE, 127, 0, 32'hFFFF_FFFF, 32'h0);
    send_item(sorpr_pkg::REQ_READ, 0, 0, 0, 0);
    send_item(sorpr_pkg::REQ_READ, 127, 127, 0, 0);
    send_item(sorpr_pkg::REQ_READ, 127, 0, 0, 0);
    send_item(sorpr_pkg::REQ_READ, 64, 100, 0, 0);
    send_item(REQ_NONE, 127, 127, 32'h1234_5678, 32'h1);
    send_item(sorpr_pkg::REQ_READ, 127, 127, 0, 0);
    drain();
  endtask

  task automatic test_solver_extremes();
    set_solver(255, 3, 32767, 32'hFFFF_FFFF, 32'h0, 2);
    send_item(sorpr_pkg::REQ_WRITE, 1, 1, 32'h0001_0000, 32'h7FFF_FFFF);
    send_item(sorpr_pkg::REQ_WRITE, 1, 126, 32'h8000_0000, 32'h8000_0000);
    send_item(sorpr_pkg::REQ_SOLVE, 0, 0, 0, 0);
    send_item(sorpr_pkg::REQ_READ, 1, 1, 0, 0);
    send_item(sorpr_pkg::REQ_READ, 1, 126, 0, 0);
    drain();
    set_solver(3, 255, 0, 32'h0, 32'h0, 0);
    send_item(sorpr_pkg::REQ_SOLVE, 0, 0, 0, 0);
    send_item(sorpr_pkg::REQ_READ, 100, 1, 0, 0);
    drain();
    set_solver(0, 0, 16384, 32'h1000_0000, 32'hFFFF_FFFF, 20'hFFFFF);
    for (int i = 0; i < 9; i++) send_item(sorpr_pkg::REQ_WRITE, i / 3, i % 3, 0, 0);
    send_item(sorpr_pkg::REQ_SOLVE, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_random_traffic(input int n_items, input int idle, input int stall);
    int sent, rows, cols, burst;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      drain();
      cols = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
      rows = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
      set_solver(cols, rows, $urandom_range(32767),
                 $urandom_range(1) ? $urandom : $urandom_range(32'h0100_0000),
                 $urandom_range(1) ? $urandom : $urandom_range(32'h0001_0000),
                 $urandom_range(1, 10));
      cols = clamp_dim(cols);
      rows = clamp_dim(rows);
      burst = $urandom_range(15, 40);
      for (int k = 0; k < burst; k++) begin
        case ($urandom_range(19))
          0: send_item(sorpr_pkg::REQ_SOLVE, 0, 0, $urandom, $urandom);
          1: send_item(REQ_NONE, $urandom_range(127), $urandom_range(127), $urandom,
                       $urandom);
          2: send_item(sorpr_pkg::REQ_WRITE, $urandom_range(127), $urandom_range(127),
                       $urandom, $urandom);
          3, 4, 5, 6, 7:
            send_item(sorpr_pkg::REQ_READ, $urandom_range(rows - 1),
                      $urandom_range(cols - 1), 0, 0);
          8: send_item(sorpr_pkg::REQ_READ, $urandom_range(127), $urandom_range(127),
                       0, 0);
          default:
            send_item(sorpr_pkg::REQ_WRITE, $urandom_range(rows - 1),
                      $urandom_range(cols - 1), cell_value(), cell_value());
        endcase
      end
      send_item(sorpr_pkg::REQ_SOLVE, 0, 0, 0, 0);
      for (int k = 0; k < 4; k++)
        send_item(sorpr_pkg::REQ_READ, $urandom_range(1, rows - 2),
                  $urandom_range(1, cols - 2), 0, 0);
      sent += burst + 5;
    end
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_solver(4, 4, 20000, 32'h0001_0000, 32'h0000_1000, 4);
    hold_end = rx_cycle + 300;
    for (int k = 0; k < 60; k++)
      send_item(k[0] ? sorpr_pkg::REQ_READ : sorpr_pkg::REQ_WRITE, $urandom_range(3),
                $urandom_range(3), cell_value(), cell_value());
    send_item(sorpr_pkg::REQ_SOLVE, 0, 0, 0, 0);
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = sorpr_pkg::REQ_WRITE;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.cell_potential = '0;
    in_ch.cell_density = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = sorpr_pkg::CFG_GRID_COLS;
    cfg_ch.wdata = '0;
    out_ch.ready = 1'b0;
    rx_cycle = 0;
    hold_end = 0;
    failures = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    last_sweeps = 0;
    last_at_limit = 1'b0;
    solves_run = 0;
    limit_stops = 0;
    reads_run = 0;
    foreach (potential_grid[k]) begin
      potential_grid[k] = 0;
      density_grid[k] = 0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_cell_access();
    test_solver_extremes();
    test_backpressure();
    test_random_traffic(200, 0, 0);
    test_random_traffic(200, 72, 0);
    test_random_traffic(200, 0, 72);
    test_random_traffic(200, 32, 32);
    $display("Covered %0d solves (%0d stopped at the sweep limit) and %0d cell reads,",
             solves_run, limit_stops, reads_run);
    $display("with register extremes, back-pressure and random idling on both sides.");
    if (failures == 0) begin
      $display("sor_poisson_relaxation verification clean");
    end else begin
      $display("sor_poisson_relaxation verification failed");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("sor_poisson_relaxation verification failed");
    $finish;
  end

endmodule
